/* src/dcap_pkg.sv */
// shared types and codes for the datagram capsule deframer
// used by dcap_parser and datagram_capsule_deframer; no dependencies
package dcap_pkg;

  localparam int unsigned LEN_W = 62;

  typedef enum logic [2:0] {
    PH_TYPE      = 3'd0,
    PH_LEN_FIRST = 3'd1,
    PH_LEN_MORE  = 3'd2,
    PH_CONTEXT   = 3'd3,
    PH_PAYLOAD   = 3'd4,
    PH_SKIP      = 3'd5,
    PH_HALT      = 3'd6
  } phase_t;

  typedef logic [3:0] kind_t;

  localparam kind_t KIND_HEADER      = 4'd0;
  localparam kind_t KIND_PAYLOAD     = 4'd1;
  localparam kind_t KIND_EMPTY       = 4'd2;
  localparam kind_t KIND_BAD_TYPE    = 4'd3;
  localparam kind_t KIND_BAD_CONTEXT = 4'd4;
  localparam kind_t KIND_ZERO_LEN    = 4'd5;
  localparam kind_t KIND_TOO_LARGE   = 4'd6;
  localparam kind_t KIND_SKIPPED     = 4'd7;
  localparam kind_t KIND_HALTED      = 4'd8;

  localparam logic [2:0] REG_MAX_PAYLOAD = 3'd0;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       payload_byte;
    logic             last;
    logic [LEN_W-1:0] datagram_length;
  } result_t;

endpackage

/* src/dcap_parser.sv */
// per-word capsule parser: phase, varint accumulator and payload countdown
// produces one result per accepted word; depends on dcap_pkg
module dcap_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [7:0]                  byte_in,
  input  logic [15:0]                 max_payload,
  output dcap_pkg::result_t           res
);

  dcap_pkg::phase_t            phase, phase_next;
  logic [dcap_pkg::LEN_W-1:0]  varint_accum, varint_accum_next;
  logic [2:0]                  varint_bytes_left, varint_bytes_left_next;
  logic [dcap_pkg::LEN_W-1:0]  payload_left, payload_left_next;
  logic [16:0]                 max_plus1;
  logic                        too_large;

  // plen > max  <=>  accum > max + 1, avoids a subtract ahead of the compare
  assign max_plus1 = {1'b0, max_payload} + 17'd1;
  assign too_large = (|varint_accum[dcap_pkg::LEN_W-1:17]) ||
                     (varint_accum[16:0] > max_plus1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= dcap_pkg::PH_TYPE;
      varint_accum      <= '0;
      varint_bytes_left <= '0;
      payload_left      <= '0;
    end else if (step) begin
      phase             <= phase_next;
      varint_accum      <= varint_accum_next;
      varint_bytes_left <= varint_bytes_left_next;
      payload_left      <= payload_left_next;
    end
  end

  always_comb begin
    phase_next             = phase;
    varint_accum_next      = varint_accum;
    varint_bytes_left_next = varint_bytes_left;
    payload_left_next      = payload_left;
    res.kind               = dcap_pkg::KIND_HEADER;
    res.payload_byte       = '0;
    res.last               = 1'b0;
    res.datagram_length    = '0;
    unique case (phase)
      dcap_pkg::PH_TYPE: begin
        if (byte_in != 8'd0) begin
          res.kind   = dcap_pkg::KIND_BAD_TYPE;
          phase_next = dcap_pkg::PH_HALT;
        end else begin
          phase_next = dcap_pkg::PH_LEN_FIRST;
        end
      end
      dcap_pkg::PH_LEN_FIRST: begin
        varint_accum_next = {{(dcap_pkg::LEN_W-6){1'b0}}, byte_in[5:0]};
        // top two bits give 1, 2, 4 or 8 bytes in all
        unique case (byte_in[7:6])
          2'd0:    varint_bytes_left_next = 3'd0;
          2'd1:    varint_bytes_left_next = 3'd1;
          2'd2:    varint_bytes_left_next = 3'd3;
          default: varint_bytes_left_next = 3'd7;
        endcase
        phase_next = (byte_in[7:6] == 2'd0) ? dcap_pkg::PH_CONTEXT
                                            : dcap_pkg::PH_LEN_MORE;
      end
      dcap_pkg::PH_LEN_MORE: begin
        varint_accum_next      = {varint_accum[dcap_pkg::LEN_W-9:0], byte_in};
        varint_bytes_left_next = varint_bytes_left - 3'd1;
        if (varint_bytes_left == 3'd1) phase_next = dcap_pkg::PH_CONTEXT;
      end
      dcap_pkg::PH_CONTEXT: begin
        if (byte_in != 8'd0) begin
          res.kind   = dcap_pkg::KIND_BAD_CONTEXT;
          phase_next = dcap_pkg::PH_HALT;
        end else if (varint_accum == '0) begin
          res.kind   = dcap_pkg::KIND_ZERO_LEN;
          phase_next = dcap_pkg::PH_HALT;
        end else begin
          res.datagram_length = varint_accum - 62'd1;
          payload_left_next   = varint_accum - 62'd1;
          if (too_large) begin
            res.kind   = dcap_pkg::KIND_TOO_LARGE;
            phase_next = dcap_pkg::PH_SKIP;
          end else if (varint_accum == 62'd1) begin
            res.kind   = dcap_pkg::KIND_EMPTY;
            res.last   = 1'b1;
            phase_next = dcap_pkg::PH_TYPE;
          end else begin
            phase_next = dcap_pkg::PH_PAYLOAD;
          end
        end
      end
      dcap_pkg::PH_PAYLOAD: begin
        res.kind          = dcap_pkg::KIND_PAYLOAD;
        res.payload_byte  = byte_in;
        payload_left_next = payload_left - 62'd1;
        if (payload_left == 62'd1) begin
          res.last   = 1'b1;
          phase_next = dcap_pkg::PH_TYPE;
        end
      end
      dcap_pkg::PH_SKIP: begin
        res.kind          = dcap_pkg::KIND_SKIPPED;
        payload_left_next = payload_left - 62'd1;
        if (payload_left == 62'd1) phase_next = dcap_pkg::PH_TYPE;
      end
      default: begin
        res.kind   = dcap_pkg::KIND_HALTED;
        phase_next = dcap_pkg::PH_HALT;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (step && phase == dcap_pkg::PH_HALT) |=> (phase == dcap_pkg::PH_HALT))
    else $error("parser left halt without reset");

  a_payload_end: assert property (@(posedge clk) disable iff (rst)
    (step && phase == dcap_pkg::PH_PAYLOAD && payload_left == 62'd1)
      |=> (phase == dcap_pkg::PH_TYPE))
    else $error("final payload word did not return to type phase");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    res.last |-> (res.kind == dcap_pkg::KIND_PAYLOAD || res.kind == dcap_pkg::KIND_EMPTY))
    else $error("last flag on a non-data result");

  a_len_more_count: assert property (@(posedge clk) disable iff (rst)
    (phase == dcap_pkg::PH_LEN_MORE) |-> (varint_bytes_left != 3'd0))
    else $error("varint continuation with no bytes left");

  a_length_at_context: assert property (@(posedge clk) disable iff (rst)
    (res.datagram_length != '0) |-> (phase == dcap_pkg::PH_CONTEXT))
    else $error("datagram length outside the context phase");
`endif

endmodule

/* src/datagram_capsule_deframer.sv */
// top level of the datagram capsule deframer: register port, parser, result register
// depends on dcap_pkg and dcap_parser
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  byte_in
//   out       output     out_valid/out_stall  kind, payload_byte, last, datagram_length
//   apb       input      psel/penable/pready  paddr, pwdata, prdata (max_payload at 0x0)
//
// one word per cycle while in_stall is low: a word is parsed in the cycle it is accepted and its result
// sits in the result register from the next cycle on
// in_stall is high only while a result is held and out_stall is high
// rst clears the parser to the type phase and sets max_payload to 65535
// a protocol error halts the parser until rst
module datagram_capsule_deframer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 byte_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [3:0]                 kind,
  output logic [7:0]                 payload_byte,
  output logic                       last,
  output logic [61:0]                datagram_length,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic              step;
  logic [15:0]       max_payload;
  dcap_pkg::result_t res;

  assign pready   = 1'b1;
  assign prdata   = (paddr == dcap_pkg::REG_MAX_PAYLOAD) ? {16'd0, max_payload} : 32'd0;
  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= 16'hFFFF;
    end else if (psel && penable && pwrite && pready &&
                 paddr == dcap_pkg::REG_MAX_PAYLOAD) begin
      max_payload <= pwdata[15:0];
    end
  end

  dcap_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .byte_in     (byte_in),
    .max_payload (max_payload),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      kind            <= res.kind;
      payload_byte    <= res.payload_byte;
      last            <= res.last;
      datagram_length <= res.datagram_length;
    end
  end

endmodule

/* tb/sv/testbench.sv */
// testbench for datagram_capsule_deframer: capsule byte streams against a byte-level parser
// predictor, every result word checked in order under sender gaps and receiver stalls
// depends on dcap_pkg and the datagram_capsule_deframer rtl
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;
  localparam logic [2:0] ADDR_MAX_PAYLOAD = dcap_pkg::REG_MAX_PAYLOAD << 2;
  localparam logic [2:0] ADDR_SPARE = 3'd4;
  localparam logic [61:0] LEN_ALL_ONES = '1;

  typedef enum int {
    END_BAD_TYPE, END_BAD_CONTEXT, END_ZERO_LEN, END_CONTEXT_FIRST, END_HUGE
  } ending_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  kind;
  logic [7:0]  payload_byte;
  logic        last;
  logic [61:0] datagram_length;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // parser state as the block should hold it
  dcap_pkg::phase_t ph_model = dcap_pkg::PH_TYPE;
  logic [61:0] len_accum = '0;
  logic [2:0]  len_bytes_left = '0;
  logic [61:0] bytes_to_go = '0;
  logic [15:0] max_payload_model = 16'hFFFF;

  dcap_pkg::result_t predicted_results[$];
  int      errors = 0;
  int      reg_errors = 0;
  int      n_bytes_sent = 0;
  int      kind_seen [0:8];
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      hold_requests = 0;
  int      hold_served = 0;
  int      hold_cycles = 0;
  int      cycles = 0;
  ending_t ending_taken = END_BAD_TYPE;

  datagram_capsule_deframer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .byte_in(byte_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .payload_byte(payload_byte), .last(last),
    .datagram_length(datagram_length),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               predicted_results.size());
      $display("[datagram_capsule_deframer] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a solid hold-off while hold_cycles runs down
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_cycles <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic dcap_pkg::result_t parse_byte(input logic [7:0] b);
    dcap_pkg::result_t r;
    logic [61:0]       plen;
    r = '0;
    r.kind = dcap_pkg::KIND_HEADER;
    case (ph_model)
      dcap_pkg::PH_TYPE: begin
        if (b != 8'd0) begin
          r.kind = dcap_pkg::KIND_BAD_TYPE;
          ph_model = dcap_pkg::PH_HALT;
        end else begin
          ph_model = dcap_pkg::PH_LEN_FIRST;
        end
      end
      dcap_pkg::PH_LEN_FIRST: begin
        len_accum = {56'd0, b[5:0]};
        // size code 3 wraps to 7 more bytes in three bits
        len_bytes_left = (3'd1 << b[7:6]) - 3'd1;
        ph_model = (len_bytes_left != 3'd0) ? dcap_pkg::PH_LEN_MORE : dcap_pkg::PH_CONTEXT;
      end
      dcap_pkg::PH_LEN_MORE: begin
        len_accum = {len_accum[53:0], b};
        len_bytes_left = len_bytes_left - 3'd1;
        if (len_bytes_left == 3'd0) ph_model = dcap_pkg::PH_CONTEXT;
      end
      dcap_pkg::PH_CONTEXT: begin
        // context is checked ahead of the zero length
        if (b != 8'd0) begin
          r.kind = dcap_pkg::KIND_BAD_CONTEXT;
          ph_model = dcap_pkg::PH_HALT;
        end else if (len_accum == '0) begin
          r.kind = dcap_pkg::KIND_ZERO_LEN;
          ph_model = dcap_pkg::PH_HALT;
        end else begin
          plen = len_accum - 62'd1;
          r.datagram_length = plen;
          if (plen > {46'd0, max_payload_model}) begin
            r.kind = dcap_pkg::KIND_TOO_LARGE;
            bytes_to_go = plen;
            ph_model = dcap_pkg::PH_SKIP;
          end else if (plen == '0) begin
            r.kind = dcap_pkg::KIND_EMPTY;
            r.last = 1'b1;
            ph_model = dcap_pkg::PH_TYPE;
          end else begin
            bytes_to_go = plen;
            ph_model = dcap_pkg::PH_PAYLOAD;
          end
        end
      end
      dcap_pkg::PH_PAYLOAD: begin
        r.kind = dcap_pkg::KIND_PAYLOAD;
        r.payload_byte = b;
        bytes_to_go = bytes_to_go - 62'd1;
        if (bytes_to_go == '0) begin
          r.last = 1'b1;
          ph_model = dcap_pkg::PH_TYPE;
        end
      end
      dcap_pkg::PH_SKIP: begin
        r.kind = dcap_pkg::KIND_SKIPPED;
        bytes_to_go = bytes_to_go - 62'd1;
        if (bytes_to_go == '0) ph_model = dcap_pkg::PH_TYPE;
      end
      default: begin
        r.kind = dcap_pkg::KIND_HALTED;
        ph_model = dcap_pkg::PH_HALT;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    dcap_pkg::result_t want;
    dcap_pkg::result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {kind, payload_byte, last, datagram_length};
      if (got.kind <= dcap_pkg::KIND_HALTED) kind_seen[got.kind]++;
      if (predicted_results.size() == 0) begin
        errors++;
        if (errors + reg_errors <= 10)
          $display("cycle %0d: result word with none expected, kind=%0d", cycles, got.kind);
      end else begin
        want = predicted_results.pop_front();
        if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
            got.last !== want.last || got.datagram_length !== want.datagram_length) begin
          errors++;
          if (errors + reg_errors <= 10) begin
            $display("cycle %0d: expected kind=%0d byte=%02h last=%0b len=%0d", cycles,
                     want.kind, want.payload_byte, want.last, want.datagram_length);
            $display("  got kind=%0d byte=%02h last=%0b len=%0d",
                     got.kind, got.payload_byte, got.last, got.datagram_length);
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_results.push_back(parse_byte(b));
    n_bytes_sent++;
  endtask

  function automatic int min_code(input logic [61:0] len);
    if (len < 62'd64) return 0;
    if (len < 62'd16384) return 1;
    if (len < 62'h4000_0000) return 2;
    return 3;
  endfunction

  // type byte, length varint of 1 << code bytes, context byte
  task automatic send_header(input logic [7:0] type_byte, input logic [61:0] len,
                             input int code, input logic [7:0] ctx);
    logic [63:0] coded;
    int          n;
    n = 1 << code;
    coded = {2'b00, len};
    coded[8*n-1 -: 2] = code[1:0];
    send_byte(type_byte);
    for (int i = n - 1; i >= 0; i--) send_byte(coded[8*i +: 8]);
    send_byte(ctx);
  endtask

  task automatic send_capsule(input int plen);
    logic [61:0] len;
    len = 62'(plen + 1);
    send_header(8'd0, len, int'($urandom_range(3, min_code(len))), 8'd0);
    repeat (plen) send_byte(8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (predicted_results.size() != 0);
  endtask

  task automatic reg_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (write && addr == ADDR_MAX_PAYLOAD) max_payload_model = wdata[15:0];
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_readback();
    logic [31:0] rd;
    reg_access(1'b0, ADDR_MAX_PAYLOAD, '0, rd);
    if (rd !== {16'd0, max_payload_model}) begin
      reg_errors++;
      if (errors + reg_errors <= 10)
        $display("max_payload reads %h, expected %h", rd, max_payload_model);
    end
  endtask

  task automatic set_max_payload(input logic [15:0] value);
    logic [31:0] unused_rd;
    wait_drained();
    reg_access(1'b1, ADDR_MAX_PAYLOAD, {16'd0, value}, unused_rd);
    check_readback();
  endtask

  task automatic test_register_port();
    logic [31:0] unused_rd;
    check_readback();
    // a write to an address with no register leaves max_payload alone
    reg_access(1'b1, ADDR_SPARE, 32'($urandom), unused_rd);
    check_readback();
  endtask

  task automatic test_directed_capsules();
    set_max_payload(16'hFFFF);
    send_header(8'd0, 62'd1, 0, 8'd0);
    send_header(8'd0, 62'd3, 1, 8'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(8'd0, 62'd2, 2, 8'd0);
    send_byte(8'hA5);
    // payload one above the limit is flagged and skipped
    set_max_payload(16'd1);
    send_header(8'd0, 62'd3, 0, 8'd0);
    send_byte(8'h5A);
    send_byte(8'hC3);
    // zero limit: empty datagrams still come through
    set_max_payload(16'd0);
    send_header(8'd0, 62'd1, 0, 8'd0);
    send_header(8'd0, 62'd2, 3, 8'd0);
    send_byte(8'h7E);
    wait_drained();
  endtask

  task automatic test_random_stream(input int gap_pct, input int stall_in_pct,
                                    input logic [15:0] max_setting, input int n_items);
    int stop_at;
    int plen;
    int pick;
    set_max_payload(max_setting);
    idle_pct = gap_pct;
    stall_pct = stall_in_pct;
    stop_at = n_bytes_sent + n_items;
    while (n_bytes_sent < stop_at) begin
      pick = int'($urandom_range(99));
      if (pick < 12) plen = 0;
      else if (pick < 85) plen = int'($urandom_range(16, 1));
      else plen = int'($urandom_range(40, 17));
      send_capsule(plen);
    end
    wait_drained();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_max_payload(16'hFFFF);
    // receiver holds off while the sender keeps offering a long capsule
    hold_requests <= hold_requests + 1;
    send_capsule(30);
    wait_drained();
  endtask

  // protocol errors halt until reset, so only one of them ends each run
  task automatic test_halt_ending();
    idle_pct = 35;
    stall_pct = 35;
    ending_taken = ending_t'($urandom_range(END_HUGE, END_BAD_TYPE));
    case (ending_taken)
      END_BAD_TYPE: send_byte(8'($urandom_range(255, 1)));
      END_BAD_CONTEXT: send_header(8'd0, 62'($urandom_range(60, 1)), 0,
                                   8'($urandom_range(255, 1)));
      END_ZERO_LEN: send_header(8'd0, '0, int'($urandom_range(3, 0)), 8'd0);
      END_CONTEXT_FIRST: send_header(8'd0, '0, 0, 8'($urandom_range(255, 1)));
      default: send_header(8'd0, LEN_ALL_ONES, 3, 8'd0);
    endcase
    repeat (40) send_byte(8'($urandom_range(255)));
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_port();
    test_directed_capsules();
    test_random_stream(0, 0, 16'hFFFF, 400);
    test_random_stream(53, 0, 16'($urandom_range(24, 2)), 400);
    test_random_stream(0, 53, 16'd1, 400);
    test_random_stream(35, 35, 16'($urandom_range(20, 8)), 400);
    test_backpressure();
    test_halt_ending();
    repeat (4) @(posedge clk);
    $display("%0d bytes parsed: %0d header, %0d payload, %0d empty, %0d too large, %0d skipped",
             n_bytes_sent, kind_seen[dcap_pkg::KIND_HEADER], kind_seen[dcap_pkg::KIND_PAYLOAD],
             kind_seen[dcap_pkg::KIND_EMPTY], kind_seen[dcap_pkg::KIND_TOO_LARGE],
             kind_seen[dcap_pkg::KIND_SKIPPED]);
    $display("stream ended by %s, %0d halted words, %0d mismatches",
             ending_taken.name(), kind_seen[dcap_pkg::KIND_HALTED], errors + reg_errors);
    if (errors + reg_errors == 0) begin
      $display("[datagram_capsule_deframer] OK");
    end else begin
      $display("[datagram_capsule_deframer] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
src/dcap_pkg.sv
src/dcap_parser.sv
src/datagram_capsule_deframer.sv
tb/sv/testbench.sv
